// ----- sv/fir_filter_circular_history_defines.svh -----
// Assertion macros for the checker file of the FIR filter.
`ifndef FIR_FILTER_CIRCULAR_HISTORY_DEFINES_SVH
`define FIR_FILTER_CIRCULAR_HISTORY_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FCCH_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FCCH_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/fcch_pkg.sv -----
`default_nettype none

package fcch_pkg;

  localparam int SAMPLE_W = 16;
  localparam int COEF_W = 16;
  localparam int INDEX_W = 6;
  localparam int TAPS_W = 7;
  localparam int CMD_W = 2;
  localparam int IN_DATA_W = 40;
  localparam int OUT_DATA_W = 32;
  localparam int OUT_USER_W = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_FILTER  = 2'd0,
    CMD_COEF_WR = 2'd1,
    CMD_COEF_RD = 2'd2,
    CMD_CLEAR   = 2'd3
  } cmd_t;

  typedef enum logic {
    REPLY_FILTER = 1'b0,
    REPLY_COEF   = 1'b1
  } reply_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN,
    ST_FLUSH,
    ST_FIN,
    ST_CREAD,
    ST_CFIN
  } state_t;

  typedef struct packed {
    logic coef_we;
    logic hist_we;
    logic hist_clr;
  } store_ctl_t;

  typedef struct packed {
    logic clear;
    logic issue;
  } mac_ctl_t;

endpackage

`default_nettype wire

// ----- sv/fcch_store.sv -----
`default_nettype none

module fcch_store #(
  parameter int MAX_TAPS = 64,
  parameter int AW = 6
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire fcch_pkg::store_ctl_t                ctl,
  input  wire logic [AW-1:0]                       coef_waddr,
  input  wire logic signed [fcch_pkg::COEF_W-1:0]   coef_wdata,
  input  wire logic [AW-1:0]                       coef_raddr,
  input  wire logic [AW-1:0]                       hist_waddr,
  input  wire logic signed [fcch_pkg::SAMPLE_W-1:0] hist_wdata,
  input  wire logic [AW-1:0]                       hist_raddr,
  output logic signed [fcch_pkg::COEF_W-1:0]        coef_rdata,
  output logic signed [fcch_pkg::SAMPLE_W-1:0]      hist_rdata
);
  import fcch_pkg::*;

  logic signed [COEF_W-1:0]   coef_mem [MAX_TAPS];
  logic signed [SAMPLE_W-1:0] hist_mem [MAX_TAPS];
  logic [MAX_TAPS-1:0]        coef_vld;
  logic [MAX_TAPS-1:0]        hist_vld;
  logic signed [COEF_W-1:0]   coef_q;
  logic signed [SAMPLE_W-1:0] hist_q;
  logic                       coef_vq;
  logic                       hist_vq;

  // Entries never written since the last reset (or, for history, clear) read as zero.
  always_ff @(posedge clk) begin
    if (ctl.coef_we) begin
      coef_mem[coef_waddr] <= coef_wdata;
    end
    if (ctl.hist_we) begin
      hist_mem[hist_waddr] <= hist_wdata;
    end
    coef_q  <= coef_mem[coef_raddr];
    hist_q  <= hist_mem[hist_raddr];
    coef_vq <= coef_vld[coef_raddr];
    hist_vq <= hist_vld[hist_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_vld <= '0;
    end else if (ctl.coef_we) begin
      coef_vld[coef_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.hist_clr) begin
      hist_vld <= '0;
    end else if (ctl.hist_we) begin
      hist_vld[hist_waddr] <= 1'b1;
    end
  end

  assign coef_rdata = coef_vq ? coef_q : '0;
  assign hist_rdata = hist_vq ? hist_q : '0;

endmodule

`default_nettype wire

// ----- sv/fcch_mac.sv -----
`default_nettype none

module fcch_mac #(
  parameter int MAX_TAPS = 64
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire fcch_pkg::mac_ctl_t                  ctl,
  input  wire logic signed [fcch_pkg::COEF_W-1:0]   coef,
  input  wire logic signed [fcch_pkg::SAMPLE_W-1:0] sample,
  output logic signed [fcch_pkg::SAMPLE_W-1:0]      filtered,
  output logic                                     saturated,
  output logic                                     busy
);
  import fcch_pkg::*;

  localparam int ACC_W = SAMPLE_W + COEF_W + $clog2(MAX_TAPS) + 1;
  localparam logic signed [ACC_W-1:0] HALF = ACC_W'(2 ** (COEF_W - 2));
  localparam logic signed [ACC_W-1:0] Y_MAX = ACC_W'(2 ** (SAMPLE_W - 1) - 1);
  localparam logic signed [ACC_W-1:0] Y_MIN = ~Y_MAX;

  logic                                 rd_vld;
  logic                                 prod_vld;
  logic signed [SAMPLE_W+COEF_W-1:0]    prod;
  logic signed [ACC_W-1:0]              acc;
  logic signed [ACC_W-1:0]              rnd;
  logic signed [ACC_W-1:0]              scaled;
  logic                                 hi;
  logic                                 lo;

  // The store answers in the cycle after a read is issued.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld   <= 1'b0;
      prod_vld <= 1'b0;
    end else begin
      rd_vld   <= ctl.issue;
      prod_vld <= rd_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_vld) begin
      prod <= coef * sample;
    end
    if (ctl.clear) begin
      acc <= '0;
    end else if (prod_vld) begin
      acc <= acc + ACC_W'(prod);
    end
  end

  // Round half up to the sample format, then clip.
  always_comb begin
    rnd       = acc + HALF;
    scaled    = rnd >>> (COEF_W - 1);
    hi        = scaled > Y_MAX;
    lo        = scaled < Y_MIN;
    saturated = hi | lo;
    if (hi) begin
      filtered = Y_MAX[SAMPLE_W-1:0];
    end else if (lo) begin
      filtered = Y_MIN[SAMPLE_W-1:0];
    end else begin
      filtered = scaled[SAMPLE_W-1:0];
    end
  end

  assign busy = rd_vld | prod_vld;

endmodule

`default_nettype wire

// ----- sv/fir_filter_circular_history.sv -----
// Channel  Direction  Signals                         Content
// s_*      in         s_tvalid s_tready s_tdata s_tuser  command transactions
// m_*      out        m_tvalid m_tready m_tdata m_tuser  filter and read replies
// cfg_*    in         cfg_valid cfg_ready cfg_data       tap_count register
//
// A filter command runs one multiply-accumulate that visits one tap per cycle
// through a two-stage read and multiply pipeline. A coefficient read passes
// through its read and reply states; coefficient writes and clears act when taken.
// Synchronous reset clears coefs, history, position; sets min(MAX_TAPS, 64) taps.
// The reply sits in an output register; a stalled reply holds the block at its end.
`default_nettype none

module fir_filter_circular_history #(
  parameter int MAX_TAPS = 64
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 s_tvalid,
  output logic                                      s_tready,
  // sample[15:0], coef_index[21:16], coef_value[37:22], zero padding[39:38]
  input  wire logic [fcch_pkg::IN_DATA_W-1:0]       s_tdata,
  // cmd[1:0]
  input  wire logic [fcch_pkg::CMD_W-1:0]           s_tuser,
  output logic                                      m_tvalid,
  input  wire logic                                 m_tready,
  // filtered[15:0], coef_read[31:16]
  output logic [fcch_pkg::OUT_DATA_W-1:0]           m_tdata,
  // reply_kind[0], saturated[1]
  output logic [fcch_pkg::OUT_USER_W-1:0]           m_tuser,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [fcch_pkg::TAPS_W-1:0]          cfg_data
);
  import fcch_pkg::*;

  localparam int AW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam logic [TAPS_W-1:0] TAPS_RST = TAPS_W'((MAX_TAPS < 64) ? MAX_TAPS : 64);

  state_t                     state;
  state_t                     state_next;
  logic [TAPS_W-1:0]          tap_count;
  logic [TAPS_W-1:0]          cfg_taps;
  logic [AW-1:0]              wr_pos;
  logic [AW-1:0]              rd_pos;
  logic [TAPS_W-1:0]          k;
  logic [INDEX_W-1:0]         idx_q;
  logic                       idx_ok;
  cmd_t                       in_cmd;
  logic signed [SAMPLE_W-1:0] in_sample;
  logic [INDEX_W-1:0]         in_idx;
  logic signed [COEF_W-1:0]   in_coef;
  logic                       in_ok;
  logic                       s_acc;
  logic                       cfg_acc;
  logic                       out_load;
  reply_t                     out_kind;
  store_ctl_t                 store_ctl;
  mac_ctl_t                   mac_ctl;
  logic [AW-1:0]              coef_raddr;
  logic signed [COEF_W-1:0]   coef_rdata;
  logic signed [SAMPLE_W-1:0] hist_rdata;
  logic signed [SAMPLE_W-1:0] mac_filtered;
  logic                       mac_saturated;
  logic                       mac_busy;

  assign in_cmd    = cmd_t'(s_tuser);
  assign in_sample = s_tdata[SAMPLE_W-1:0];
  assign in_idx    = s_tdata[SAMPLE_W+INDEX_W-1:SAMPLE_W];
  assign in_coef   = s_tdata[SAMPLE_W+INDEX_W+COEF_W-1:SAMPLE_W+INDEX_W];
  assign in_ok     = TAPS_W'(in_idx) < tap_count;
  assign s_acc     = s_tvalid && s_tready;
  assign cfg_acc   = cfg_valid && cfg_ready;

  always_comb begin
    if (cfg_data == '0) begin
      cfg_taps = TAPS_W'(1);
    end else if (int'(cfg_data) > MAX_TAPS) begin
      cfg_taps = TAPS_W'(MAX_TAPS);
    end else begin
      cfg_taps = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    cfg_ready  = 1'b0;
    store_ctl  = '0;
    mac_ctl    = '0;
    out_load   = 1'b0;
    out_kind   = REPLY_FILTER;
    unique case (state)
      ST_IDLE: begin
        cfg_ready = 1'b1;
        s_tready  = !cfg_valid;
        if (cfg_valid) begin
          store_ctl.hist_clr = 1'b1;
        end else if (s_tvalid) begin
          unique case (in_cmd)
            CMD_FILTER: begin
              store_ctl.hist_we = 1'b1;
              mac_ctl.clear     = 1'b1;
              state_next        = ST_RUN;
            end
            CMD_COEF_WR: begin
              store_ctl.coef_we = in_ok;
            end
            CMD_COEF_RD: begin
              state_next = ST_CREAD;
            end
            CMD_CLEAR: begin
              store_ctl.hist_clr = 1'b1;
            end
          endcase
        end
      end
      ST_RUN: begin
        mac_ctl.issue = 1'b1;
        if (k == tap_count - TAPS_W'(1)) begin
          state_next = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!mac_busy) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          out_kind   = REPLY_FILTER;
          state_next = ST_IDLE;
        end
      end
      ST_CREAD: begin
        state_next = ST_CFIN;
      end
      ST_CFIN: begin
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          out_kind   = REPLY_COEF;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tap_count <= TAPS_RST;
      wr_pos    <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      if (cfg_acc) begin
        tap_count <= cfg_taps;
        wr_pos    <= '0;
      end else if (s_acc && in_cmd == CMD_FILTER) begin
        if (int'(wr_pos) + 1 >= int'(tap_count)) begin
          wr_pos <= '0;
        end else begin
          wr_pos <= wr_pos + AW'(1);
        end
      end else if (s_acc && in_cmd == CMD_CLEAR) begin
        wr_pos <= '0;
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_acc) begin
      rd_pos <= wr_pos;
      k      <= '0;
      idx_q  <= in_idx;
      idx_ok <= in_ok;
    end else if (state == ST_RUN) begin
      k <= k + TAPS_W'(1);
      if (rd_pos == '0) begin
        rd_pos <= AW'(tap_count - TAPS_W'(1));
      end else begin
        rd_pos <= rd_pos - AW'(1);
      end
    end
    if (out_load) begin
      if (out_kind == REPLY_FILTER) begin
        m_tdata <= {{COEF_W{1'b0}}, mac_filtered};
        m_tuser <= {mac_saturated, REPLY_FILTER};
      end else begin
        m_tdata <= {(idx_ok ? coef_rdata : {COEF_W{1'b0}}), {SAMPLE_W{1'b0}}};
        m_tuser <= {1'b0, REPLY_COEF};
      end
    end
  end

  assign coef_raddr = (state == ST_RUN) ? AW'(k) : AW'(idx_q);

  fcch_store #(
    .MAX_TAPS(MAX_TAPS),
    .AW(AW)
  ) u_store (
    .clk(clk),
    .rst(rst),
    .ctl(store_ctl),
    .coef_waddr(AW'(in_idx)),
    .coef_wdata(in_coef),
    .coef_raddr(coef_raddr),
    .hist_waddr(wr_pos),
    .hist_wdata(in_sample),
    .hist_raddr(rd_pos),
    .coef_rdata(coef_rdata),
    .hist_rdata(hist_rdata)
  );

  fcch_mac #(
    .MAX_TAPS(MAX_TAPS)
  ) u_mac (
    .clk(clk),
    .rst(rst),
    .ctl(mac_ctl),
    .coef(coef_rdata),
    .sample(hist_rdata),
    .filtered(mac_filtered),
    .saturated(mac_saturated),
    .busy(mac_busy)
  );

endmodule

`default_nettype wire

// ----- sv/fcch_checker.sv -----
`default_nettype none
`include "fir_filter_circular_history_defines.svh"

module fcch_checker (
  input wire logic                             clk,
  input wire logic                             rst,
  input wire logic                             s_tvalid,
  input wire logic                             s_tready,
  input wire logic [fcch_pkg::CMD_W-1:0]       s_tuser,
  input wire logic                             m_tvalid,
  input wire logic                             m_tready,
  input wire logic [fcch_pkg::OUT_DATA_W-1:0]  m_tdata,
  input wire logic [fcch_pkg::OUT_USER_W-1:0]  m_tuser,
  input wire logic                             cfg_ready
);
  import fcch_pkg::*;

  logic        filter_acc;
  logic        coef_out;
  logic        clip_out;
  logic        coef_clean;
  logic        at_limit;
  logic [15:0] out_lo;

  assign filter_acc = s_tvalid && s_tready && s_tuser == CMD_FILTER;
  assign coef_out   = m_tvalid && m_tuser[0] == REPLY_COEF;
  assign clip_out   = m_tvalid && m_tuser[1];
  assign out_lo     = m_tdata[15:0];
  assign coef_clean = out_lo == 16'h0000 && !m_tuser[1];
  assign at_limit   = out_lo == 16'h7fff || out_lo == 16'h8000;

  // A reply that is not taken stays on offer.
  `FCCH_ASSERT_NEXT(a_reply_held, clk, rst, m_tvalid && !m_tready, m_tvalid, "reply dropped")

  // A filter transaction keeps the input closed while the taps are walked.
  `FCCH_ASSERT_NEXT(a_filter_busy, clk, rst, filter_acc, !s_tready, "input reopened")

  // A coefficient reply leaves the filter reply's fields at zero.
  `FCCH_ASSERT_SAME(a_coef_reply, clk, rst, coef_out, coef_clean, "stray filter data")

  // A clipped output sits at one of the two limits of the sample range.
  `FCCH_ASSERT_SAME(a_clip_limit, clk, rst, clip_out, at_limit, "clip off limit")

  // Commands are only taken when the configuration channel is also open.
  `FCCH_ASSERT_SAME(a_ready_idle, clk, rst, s_tready, cfg_ready, "input ready outside idle")

endmodule

bind fir_filter_circular_history fcch_checker u_fcch_checker (.*);

`default_nettype wire
